[rtl/mlpfs_pkg.sv]
// shared types and constants for the multilevel priority fifo scheduler
`timescale 1ns / 1ps
package mlpfs_pkg;

	localparam int NUM_LEVELS   = 4;
	localparam int QUEUE_DEPTH  = 16;
	localparam int ID_BITS      = 8;

	localparam int LEVEL_BITS   = $clog2(NUM_LEVELS);
	localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_BITS    = $clog2(NUM_LEVELS * QUEUE_DEPTH);

	localparam int PORT_ID_BITS    = 8;
	localparam int PORT_LEVEL_BITS = 2;

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_DONE    = 1'b1;

	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [PTR_BITS-1:0]   ptr_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;

	// push and pop requests from the control logic to the wait queues
	typedef struct packed {
		logic   push_en;
		level_t push_level;
		id_t    push_id;
		logic   pop_en;
		level_t pop_level;
	} queue_cmd_t;

	// per-level occupancy as seen by the control logic
	typedef struct packed {
		logic [NUM_LEVELS-1:0] full;
		logic                  any_busy;
		level_t                best_level;
	} queue_status_t;

	// requests above the last level land on the last level
	function automatic level_t sat_level(input logic [PORT_LEVEL_BITS-1:0] prio);
		level_t lvl;
		if (int'(prio) >= NUM_LEVELS)
			lvl = level_t'(NUM_LEVELS - 1);
		else
			lvl = level_t'(prio);
		return lvl;
	endfunction

endpackage

[rtl/mlpfs_wait_queues.sv]
// per-level wait fifos sharing one id memory, with the highest-busy-level encoder
`timescale 1ns / 1ps
module mlpfs_wait_queues
	import mlpfs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_cmd_t    cmd,
	output queue_status_t status,
	output id_t           rd_data
);

	ptr_t head_q [NUM_LEVELS];
	ptr_t tail_q [NUM_LEVELS];
	cnt_t count_q [NUM_LEVELS];
	id_t  mem [NUM_LEVELS * QUEUE_DEPTH];
	id_t  rd_q;

	function automatic ptr_t next_slot(input ptr_t p);
		ptr_t n;
		if (int'(p) == QUEUE_DEPTH - 1)
			n = '0;
		else
			n = p + ptr_t'(1);
		return n;
	endfunction

	function automatic addr_t slot_addr(input level_t lvl, input ptr_t p);
		return addr_t'(int'(lvl) * QUEUE_DEPTH + int'(p));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				logic push_here;
				logic pop_here;
				push_here = cmd.push_en && (cmd.push_level == level_t'(l));
				pop_here  = cmd.pop_en && (cmd.pop_level == level_t'(l));
				if (push_here)
					tail_q[l] <= next_slot(tail_q[l]);
				if (pop_here)
					head_q[l] <= next_slot(head_q[l]);
				if (push_here && !pop_here)
					count_q[l] <= count_q[l] + cnt_t'(1);
				else if (pop_here && !push_here)
					count_q[l] <= count_q[l] - cnt_t'(1);
			end
		end
	end

	// read returns the old entry when push and pop hit the same slot
	always_ff @(posedge clk) begin
		if (cmd.push_en)
			mem[slot_addr(cmd.push_level, tail_q[cmd.push_level])] <= cmd.push_id;
		if (cmd.pop_en)
			rd_q <= mem[slot_addr(cmd.pop_level, head_q[cmd.pop_level])];
	end

	always_comb begin
		logic [NUM_LEVELS-1:0] busy;
		status.best_level = level_t'(NUM_LEVELS - 1);
		for (int l = 0; l < NUM_LEVELS; l++) begin
			busy[l]        = (count_q[l] != '0);
			status.full[l] = (int'(count_q[l]) >= QUEUE_DEPTH);
		end
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (busy[l])
				status.best_level = level_t'(l);
		end
		status.any_busy = |busy;
	end

	assign rd_data = rd_q;

endmodule

[rtl/multilevel_priority_fifo_scheduler_unit.sv]
// top level of the multilevel priority fifo scheduler
`timescale 1ns / 1ps
// Single-processor scheduler with one fifo of waiting ids per priority level
// (level 0 highest). A beat carries either a request or a done event; each
// accepted beat yields exactly one result beat giving the running process and
// the queued, overflow and idle-done flags. One beat is accepted every cycle
// while the output is not stalled; a beat is taken into the input register,
// worked there, and its result is then presented from the result register.
// The input stalls only while a result beat waits under an output stall.
// Waiting ids live in one shared memory of NUM_LEVELS x QUEUE_DEPTH entries
// with one write and one registered read per cycle; an id popped from it is
// forwarded from the read register, so back-to-back pops need no stall. The
// memory needs no clearing pass after reset: only entries counted as filled
// are ever read.
module multilevel_priority_fifo_scheduler_unit
	import mlpfs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [7:0]                 process_id,
	input  logic [1:0]                 priority_req,
	input  logic                       last_instruction,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       running_valid,
	output logic [PORT_ID_BITS-1:0]    running_id,
	output logic [PORT_LEVEL_BITS-1:0] running_priority,
	output logic                       request_queued,
	output logic                       queue_overflow,
	output logic                       idle_done_error
);

	logic   adv;
	logic   valid_s1;
	logic   action_s1;
	id_t    id_s1;
	level_t level_s1;
	logic   last_s1;

	logic   valid_s2;
	logic   queued_s2;
	logic   overflow_s2;
	logic   idle_err_s2;

	logic   run_valid_q;
	id_t    run_id_q;
	level_t run_level_q;
	logic   run_from_mem_q;

	queue_cmd_t    qcmd;
	queue_status_t qstat;
	id_t           rd_data;
	id_t           run_id_eff;

	logic   nxt_run_valid;
	id_t    nxt_run_id;
	level_t nxt_run_level;
	logic   nxt_from_mem;
	logic   nxt_queued;
	logic   nxt_overflow;
	logic   nxt_idle_err;

	assign adv      = !(valid_s2 && out_stall);
	assign in_stall = !adv;

	// the runner id sits in the memory read register right after a pop
	assign run_id_eff = run_from_mem_q ? rd_data : run_id_q;

	mlpfs_wait_queues u_queues (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (qcmd),
		.status  (qstat),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= action;
			id_s1     <= id_t'(process_id);
			level_s1  <= sat_level(priority_req);
			last_s1   <= last_instruction;
		end
	end

	always_comb begin
		logic work;
		work          = adv && valid_s1;
		qcmd          = '0;
		nxt_run_valid = run_valid_q;
		nxt_run_id    = run_id_q;
		nxt_run_level = run_level_q;
		nxt_from_mem  = run_from_mem_q;
		nxt_queued    = 1'b0;
		nxt_overflow  = 1'b0;
		nxt_idle_err  = 1'b0;
		if (work) begin
			if (action_s1 == ACT_REQUEST) begin
				if (!run_valid_q) begin
					nxt_run_valid = 1'b1;
					nxt_run_id    = id_s1;
					nxt_run_level = level_s1;
					nxt_from_mem  = 1'b0;
				end else if (!qstat.full[level_s1]) begin
					qcmd.push_en    = 1'b1;
					qcmd.push_level = level_s1;
					qcmd.push_id    = id_s1;
					nxt_queued      = 1'b1;
				end else begin
					nxt_overflow = 1'b1;
				end
			end else if (!run_valid_q) begin
				nxt_idle_err = 1'b1;
			end else if (!qstat.any_busy) begin
				if (last_s1) begin
					nxt_run_valid = 1'b0;
					nxt_run_id    = '0;
					nxt_run_level = '0;
					nxt_from_mem  = 1'b0;
				end
			end else if (last_s1 || (qstat.best_level <= run_level_q)) begin
				qcmd.pop_en   = 1'b1;
				qcmd.pop_level = qstat.best_level;
				nxt_run_level = qstat.best_level;
				nxt_from_mem  = 1'b1;
				if (!last_s1) begin
					// a pop from the runner's own level frees the slot it needs
					if ((qstat.best_level == run_level_q) || !qstat.full[run_level_q]) begin
						qcmd.push_en    = 1'b1;
						qcmd.push_level = run_level_q;
						qcmd.push_id    = run_id_eff;
					end else begin
						nxt_overflow = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			queued_s2      <= 1'b0;
			overflow_s2    <= 1'b0;
			idle_err_s2    <= 1'b0;
			run_valid_q    <= 1'b0;
			run_id_q       <= '0;
			run_level_q    <= '0;
			run_from_mem_q <= 1'b0;
		end else if (adv) begin
			valid_s2       <= valid_s1;
			queued_s2      <= nxt_queued;
			overflow_s2    <= nxt_overflow;
			idle_err_s2    <= nxt_idle_err;
			run_valid_q    <= nxt_run_valid;
			run_id_q       <= nxt_run_id;
			run_level_q    <= nxt_run_level;
			run_from_mem_q <= nxt_from_mem;
		end
	end

	assign out_valid        = valid_s2;
	assign running_valid    = run_valid_q;
	assign running_id       = run_valid_q ? PORT_ID_BITS'(run_id_eff) : '0;
	assign running_priority = run_valid_q ? PORT_LEVEL_BITS'(run_level_q) : '0;
	assign request_queued   = queued_s2;
	assign queue_overflow   = overflow_s2;
	assign idle_done_error  = idle_err_s2;

endmodule

[rtl/mlpfs_checker.sv]
// port-level assertions for the scheduler, bound to the top level
`timescale 1ns / 1ps
module mlpfs_checker
	import mlpfs_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       running_valid,
	input logic [PORT_ID_BITS-1:0]    running_id,
	input logic [PORT_LEVEL_BITS-1:0] running_priority,
	input logic                       request_queued,
	input logic                       queue_overflow,
	input logic                       idle_done_error
);

	// an idle processor reports no id and no level
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running_valid |-> running_id == '0 && running_priority == '0)
		else $error("idle result carries a running id or level");

	// a done beat while idle leaves the processor idle
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle_done_error |-> !running_valid)
		else $error("idle done error with a running process");

	// a queued request means the processor was busy, and flags never combine
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({request_queued, queue_overflow, idle_done_error})
			&& (!request_queued || running_valid))
		else $error("inconsistent result flags");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(running_valid)
			&& $stable(running_id) && $stable(running_priority)
			&& $stable(request_queued) && $stable(queue_overflow)
			&& $stable(idle_done_error))
		else $error("stalled result beat changed");

endmodule

bind multilevel_priority_fifo_scheduler_unit mlpfs_checker u_mlpfs_checker (.*);
